[design/key_depth_normalize_hysteresis_defines.svh]
// assertion macros used by the checker file
`ifndef KEY_DEPTH_NORMALIZE_HYSTERESIS_DEFINES_SVH
`define KEY_DEPTH_NORMALIZE_HYSTERESIS_DEFINES_SVH

// same-cycle implication, off while in reset
`define KDNH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kdnh check failed");

// next-cycle implication, off while in reset
`define KDNH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kdnh check failed");

// next-cycle implication that also covers the reset cycles
`define KDNH_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("kdnh reset check failed");

`endif

[design/kdnh_pkg.sv]
package kdnh_pkg;

  localparam int FIELD_W = 10;
  localparam int DEPTH_W = 8;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CAL    = 1'b1;

  localparam logic REG_ACTUATION = 1'b0;
  localparam logic REG_RELEASE   = 1'b1;

  localparam logic [DEPTH_W-1:0] ACT_RESET = 8'd128;
  localparam logic [DEPTH_W-1:0] REL_RESET = 8'd96;

  typedef struct packed {
    logic               opcode;
    logic [1:0]         key_row;
    logic [2:0]         key_col;
    logic [FIELD_W-1:0] raw_sample;
    logic [FIELD_W-1:0] cal_low;
    logic [FIELD_W-1:0] cal_high;
  } sample_item_t;

  typedef struct packed {
    logic [1:0]         out_row;
    logic [2:0]         out_col;
    logic [DEPTH_W-1:0] key_depth;
    logic               key_pressed;
  } result_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP,
    S_START,
    S_DIV,
    S_FINISH
  } state_t;

endpackage

[design/kdnh_store.sv]
module kdnh_store #(
  parameter int KEYS  = 28,
  parameter int KEY_W = 5,
  parameter int SB    = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cal_we,
  input  logic [KEY_W-1:0] cal_waddr,
  input  logic [SB-1:0]    cal_low,
  input  logic [SB-1:0]    cal_high,
  input  logic             flag_we,
  input  logic [KEY_W-1:0] flag_waddr,
  input  logic             flag_wdata,
  input  logic             rd_en,
  input  logic [KEY_W-1:0] rd_addr,
  output logic [SB-1:0]    rd_low,
  output logic [SB-1:0]    rd_high,
  output logic             rd_flag
);

  logic [2*SB-1:0] cal_mem [KEYS];
  logic            flag_mem [KEYS];
  logic [KEYS-1:0] flag_vld;

  logic [2*SB-1:0] rd_cal;
  logic            rd_flag_raw;
  logic            rd_flag_vld;

  // calibration bounds, high in the upper half
  always_ff @(posedge clk) begin
    if (cal_we) begin
      cal_mem[cal_waddr] <= {cal_high, cal_low};
    end
    if (rd_en) begin
      rd_cal <= cal_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    if (rd_en) begin
      rd_flag_raw <= flag_mem[rd_addr];
    end
  end

  // never-written flags read as released
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_vld    <= '0;
      rd_flag_vld <= 1'b0;
    end else begin
      if (flag_we) begin
        flag_vld[flag_waddr] <= 1'b1;
      end
      if (rd_en) begin
        rd_flag_vld <= flag_vld[rd_addr];
      end
    end
  end

  assign rd_low  = rd_cal[SB-1:0];
  assign rd_high = rd_cal[2*SB-1:SB];
  assign rd_flag = rd_flag_vld & rd_flag_raw;

endmodule

[design/kdnh_div.sv]
module kdnh_div #(
  parameter int NUM_W = 18,
  parameter int DEN_W = 10,
  parameter int Q_W   = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  output kdnh_pkg::div_stat_t stat,
  output logic [Q_W-1:0]      quot
);

  localparam int CNT_W = (Q_W > 1) ? $clog2(Q_W) : 1;

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [Q_W-1:0]   nsh;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_next;
  logic [Q_W-1:0]   nsh_next;

  // one quotient bit per cycle, quotient bits shift in behind the numerator
  always_comb begin
    trial    = {rem, nsh[Q_W-1]};
    ge       = (trial >= {1'b0, den_q});
    rem_next = ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
    nsh_next = {nsh[Q_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[NUM_W-1:Q_W];
      nsh   <= num[Q_W-1:0];
      den_q <= den;
    end else if (busy) begin
      rem <= rem_next;
      nsh <= nsh_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(Q_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot      = nsh;

endmodule

[design/key_depth_normalize_hysteresis.sv]
// calibration item: written in its accept cycle, the block is ready again the next cycle
// sample item: the stall holds from accept through the clamp, start, divide and finish
// states until the result register loads; a zero or inverted span skips the 8-step
// bit-serial divider, and no new sample item is taken while one is in flight
// the result register frees the input side while a result waits to be taken
// reset: config to 128 / 96, all pressed flags released, bounds undefined until written
module key_depth_normalize_hysteresis #(
  parameter int ROWS        = 4,
  parameter int COLS        = 7,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  kdnh_pkg::sample_item_t sample,
  output logic                   result_valid,
  input  logic                   result_stall,
  output kdnh_pkg::result_item_t result
);

  localparam int KEYS  = ROWS * COLS;
  localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int DW    = kdnh_pkg::DEPTH_W;
  localparam int NUM_W = SAMPLE_BITS + DW;

  kdnh_pkg::state_t state, state_next;

  logic [DW-1:0] actuation_level;
  logic [DW-1:0] release_level;

  logic             accept;
  logic             in_range;
  logic [KEY_W-1:0] key_idx;
  logic             cal_we;
  logic             rd_en;

  logic [KEY_W-1:0]       key;
  logic [1:0]             row;
  logic [2:0]             col;
  logic [SAMPLE_BITS-1:0] raw;

  logic [SAMPLE_BITS-1:0] rd_low;
  logic [SAMPLE_BITS-1:0] rd_high;
  logic                   rd_flag;

  logic [SAMPLE_BITS-1:0] clip_hi;
  logic [SAMPLE_BITS-1:0] clip;
  logic [SAMPLE_BITS-1:0] diff;
  logic [SAMPLE_BITS-1:0] span;
  logic                   span_zero;
  logic [NUM_W-1:0]       num;

  kdnh_pkg::div_stat_t div_stat;
  logic [DW-1:0]       quot;
  logic                div_start;

  logic [DW-1:0] depth;
  logic          pressed_next;
  logic          out_free;
  logic          out_load;
  logic          flag_we;
  logic          depth_zero;
  logic          depth_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      actuation_level <= kdnh_pkg::ACT_RESET;
      release_level   <= kdnh_pkg::REL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        kdnh_pkg::REG_ACTUATION: actuation_level <= cfg_data;
        kdnh_pkg::REG_RELEASE:   release_level   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sample_stall = (state != kdnh_pkg::S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign in_range     = (32'(sample.key_row) < ROWS) && (32'(sample.key_col) < COLS);
  assign key_idx      = KEY_W'(32'(sample.key_row) * COLS + 32'(sample.key_col));
  assign cal_we       = accept && in_range && (sample.opcode == kdnh_pkg::OP_CAL);
  assign rd_en        = accept && in_range && (sample.opcode == kdnh_pkg::OP_SAMPLE);

  kdnh_store #(
    .KEYS  (KEYS),
    .KEY_W (KEY_W),
    .SB    (SAMPLE_BITS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .cal_we     (cal_we),
    .cal_waddr  (key_idx),
    .cal_low    (SAMPLE_BITS'(sample.cal_low)),
    .cal_high   (SAMPLE_BITS'(sample.cal_high)),
    .flag_we    (flag_we),
    .flag_waddr (key),
    .flag_wdata (pressed_next),
    .rd_en      (rd_en),
    .rd_addr    (key_idx),
    .rd_low     (rd_low),
    .rd_high    (rd_high),
    .rd_flag    (rd_flag)
  );

  // clamp into [low, high]
  always_comb begin
    clip_hi = (raw > rd_high) ? rd_high : raw;
    clip    = (clip_hi < rd_low) ? rd_low : clip_hi;
  end

  // 255 * diff as a shift and subtract
  assign num = {diff, {DW{1'b0}}} - NUM_W'(diff);

  kdnh_div #(
    .NUM_W (NUM_W),
    .DEN_W (SAMPLE_BITS),
    .Q_W   (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (span),
    .stat  (div_stat),
    .quot  (quot)
  );

  assign pressed_next = rd_flag ? !(depth < release_level) : (depth > actuation_level);
  assign out_free     = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kdnh_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    flag_we    = 1'b0;
    out_load   = 1'b0;
    depth_zero = 1'b0;
    depth_take = 1'b0;
    case (state)
      kdnh_pkg::S_IDLE: begin
        if (rd_en) begin
          state_next = kdnh_pkg::S_CLAMP;
        end
      end
      kdnh_pkg::S_CLAMP: begin
        state_next = kdnh_pkg::S_START;
      end
      kdnh_pkg::S_START: begin
        if (span_zero) begin
          depth_zero = 1'b1;
          state_next = kdnh_pkg::S_FINISH;
        end else begin
          div_start  = 1'b1;
          state_next = kdnh_pkg::S_DIV;
        end
      end
      kdnh_pkg::S_DIV: begin
        if (div_stat.done) begin
          depth_take = 1'b1;
          state_next = kdnh_pkg::S_FINISH;
        end
      end
      kdnh_pkg::S_FINISH: begin
        if (out_free) begin
          flag_we    = 1'b1;
          out_load   = 1'b1;
          state_next = kdnh_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = kdnh_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      key <= key_idx;
      row <= sample.key_row;
      col <= sample.key_col;
      raw <= SAMPLE_BITS'(sample.raw_sample);
    end
    if (state == kdnh_pkg::S_CLAMP) begin
      diff      <= clip - rd_low;
      span      <= rd_high - rd_low;
      span_zero <= (rd_high <= rd_low);
    end
    if (depth_zero) begin
      depth <= '0;
    end else if (depth_take) begin
      depth <= quot;
    end
    if (out_load) begin
      result.out_row     <= row;
      result.out_col     <= col;
      result.key_depth   <= depth;
      result.key_pressed <= pressed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

[design/kdnh_chk.sv]
`include "key_depth_normalize_hysteresis_defines.svh"

module kdnh_chk #(
  parameter int ROWS = 4,
  parameter int COLS = 7
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   sample_valid,
  input logic                   sample_stall,
  input kdnh_pkg::sample_item_t sample,
  input logic                   result_valid,
  input logic                   result_stall,
  input kdnh_pkg::result_item_t result
);

  logic accept;
  logic busy_item;
  logic taken;

  assign accept    = sample_valid && !sample_stall;
  assign busy_item = (sample.opcode == kdnh_pkg::OP_SAMPLE) &&
                     (32'(sample.key_row) < ROWS) && (32'(sample.key_col) < COLS);
  assign taken     = result_valid && !result_stall;

  // an in-range sample holds the input side for its computation
  `KDNH_ASSERT_NEXT(a_sample_busy, accept && busy_item, sample_stall)
  // calibration and out-of-range items leave the block ready
  `KDNH_ASSERT_NEXT(a_other_ready, accept && !busy_item, !sample_stall)
  // a waiting result stays put
  `KDNH_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
  // a taken result never shows up again without new work in flight
  `KDNH_ASSERT_NOW(a_no_result_idle, $past(taken && !sample_stall), !result_valid)
  // reset empties the result register and leaves the input side ready
  `KDNH_ASSERT_RESET(a_reset_empty, rst, !result_valid && !sample_stall)

endmodule

bind key_depth_normalize_hysteresis kdnh_chk #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_kdnh_chk (.*);

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int NUM_ROWS = 4;
  localparam int NUM_COLS = 7;
  localparam int NUM_KEYS = NUM_ROWS * NUM_COLS;
  localparam int DEPTH_FULL = 255;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = kdnh_pkg::REG_ACTUATION;
  logic [7:0] cfg_data = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  kdnh_pkg::sample_item_t sample_in = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  kdnh_pkg::result_item_t result_out;

  key_depth_normalize_hysteresis DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample_in),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scoreboard side: mirror of the key tables and levels
  logic [9:0] lo_bound [NUM_KEYS];
  logic [9:0] hi_bound [NUM_KEYS];
  bit pressed_now [NUM_KEYS];
  logic [7:0] act_level = kdnh_pkg::ACT_RESET;
  logic [7:0] rel_level = kdnh_pkg::REL_RESET;
  kdnh_pkg::result_item_t depth_expect[$];

  // stimulus side: which keys already have bounds queued
  bit known_cal [NUM_KEYS];
  int unsigned gen_lo [NUM_KEYS];
  int unsigned gen_hi [NUM_KEYS];
  kdnh_pkg::sample_item_t pending[$];

  bit steady = 1'b0;
  int mismatches = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stuck_cycles = 0;

  initial begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      pressed_now[i] = 1'b0;
      known_cal[i] = 1'b0;
    end
  end

  task automatic track_key_item(input kdnh_pkg::sample_item_t it);
    int unsigned k, v, lo, hi, depth;
    kdnh_pkg::result_item_t r;
    if (it.key_row >= NUM_ROWS || it.key_col >= NUM_COLS) return;
    k = 32'(it.key_row) * NUM_COLS + 32'(it.key_col);
    if (it.opcode == kdnh_pkg::OP_CAL) begin
      lo_bound[k] = it.cal_low;
      hi_bound[k] = it.cal_high;
      return;
    end
    lo = 32'(lo_bound[k]);
    hi = 32'(hi_bound[k]);
    v = 32'(it.raw_sample);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    depth = (hi <= lo) ? 0 : (DEPTH_FULL * (v - lo)) / (hi - lo);
    if (!pressed_now[k] && depth > act_level) pressed_now[k] = 1'b1;
    else if (pressed_now[k] && depth < rel_level) pressed_now[k] = 1'b0;
    r.out_row = it.key_row;
    r.out_col = it.key_col;
    r.key_depth = depth[7:0];
    r.key_pressed = pressed_now[k];
    depth_expect.push_back(r);
  endtask

  task automatic queue_item(input kdnh_pkg::sample_item_t it);
    int unsigned k;
    if (it.opcode == kdnh_pkg::OP_CAL && it.key_row < NUM_ROWS && it.key_col < NUM_COLS) begin
      k = 32'(it.key_row) * NUM_COLS + 32'(it.key_col);
      known_cal[k] = 1'b1;
      gen_lo[k] = 32'(it.cal_low);
      gen_hi[k] = 32'(it.cal_high);
    end
    pending.push_back(it);
  endtask

  function automatic kdnh_pkg::sample_item_t make_item(input logic op, input int row,
                                                       input int col, input int raw,
                                                       input int lo, input int hi);
    kdnh_pkg::sample_item_t it;
    it.opcode = op;
    it.key_row = row[1:0];
    it.key_col = col[2:0];
    it.raw_sample = raw[9:0];
    it.cal_low = lo[9:0];
    it.cal_high = hi[9:0];
    return it;
  endfunction

  function automatic kdnh_pkg::sample_item_t pick_random_item();
    kdnh_pkg::sample_item_t it;
    int unsigned roll, k;
    logic [9:0] tmp;
    it.opcode = kdnh_pkg::OP_SAMPLE;
    it.key_row = 2'($urandom_range(NUM_ROWS - 1));
    it.key_col = 3'($urandom_range(NUM_COLS - 1));
    it.raw_sample = 10'($urandom_range(1023));
    it.cal_low = 10'($urandom_range(1023));
    it.cal_high = 10'($urandom_range(1023));
    k = 32'(it.key_row) * NUM_COLS + 32'(it.key_col);
    roll = $urandom_range(99);
    if (roll < 5) begin
      // column past the matrix edge
      it.key_col = 3'd7;
      it.opcode = 1'($urandom_range(1));
    end else if (roll < 20 || !known_cal[k]) begin
      it.opcode = kdnh_pkg::OP_CAL;
      if ($urandom_range(99) < 75 && it.cal_low > it.cal_high) begin
        tmp = it.cal_low;
        it.cal_low = it.cal_high;
        it.cal_high = tmp;
      end
    end else if (roll < 60 && gen_hi[k] > gen_lo[k]) begin
      it.raw_sample = 10'($urandom_range(gen_hi[k], gen_lo[k]));
    end
    return it;
  endfunction

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == kdnh_pkg::REG_ACTUATION) act_level = val;
    else rel_level = val;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() != 0 || sample_valid || depth_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int n, input bit calm);
    @(negedge clk);
    steady = calm;
    repeat (n) queue_item(pick_random_item());
    wait_idle();
    @(negedge clk);
    steady = 1'b0;
  endtask

  task automatic run_levels(input logic [7:0] act, input logic [7:0] rel, input int n,
                            input bit calm);
    write_reg(kdnh_pkg::REG_ACTUATION, act);
    write_reg(kdnh_pkg::REG_RELEASE, rel);
    run_random(n, calm);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // full range, then hysteresis around the reset levels
    queue_item(make_item(kdnh_pkg::OP_CAL, 0, 0, 0, 0, 1023));
    queue_item(make_item(kdnh_pkg::OP_SAMPLE, 0, 0, 0, 1023, 0));
    queue_item(make_item(kdnh_pkg::OP_SAMPLE, 0, 0, 1023, 0, 1023));
    queue_item(make_item(kdnh_pkg::OP_SAMPLE, 0, 0, 512, 0, 0));
    // depth equals the reading here
    queue_item(make_item(kdnh_pkg::OP_CAL, 2, 3, 0, 0, 255));
    queue_item(make_item(kdnh_pkg::OP_SAMPLE, 2, 3, 128, 0, 0));
    queue_item(make_item(kdnh_pkg::OP_SAMPLE, 2, 3, 129, 0, 0));
    queue_item(make_item(kdnh_pkg::OP_SAMPLE, 2, 3, 96, 0, 0));
    queue_item(make_item(kdnh_pkg::OP_SAMPLE, 2, 3, 95, 0, 0));
    // inverted and zero spans
    queue_item(make_item(kdnh_pkg::OP_CAL, 3, 6, 0, 1023, 0));
    queue_item(make_item(kdnh_pkg::OP_SAMPLE, 3, 6, 700, 0, 0));
    queue_item(make_item(kdnh_pkg::OP_CAL, 1, 2, 0, 500, 500));
    queue_item(make_item(kdnh_pkg::OP_SAMPLE, 1, 2, 500, 0, 0));
    // clamping on both sides
    queue_item(make_item(kdnh_pkg::OP_CAL, 1, 4, 0, 100, 900));
    queue_item(make_item(kdnh_pkg::OP_SAMPLE, 1, 4, 50, 0, 0));
    queue_item(make_item(kdnh_pkg::OP_SAMPLE, 1, 4, 1000, 0, 0));
    // keys off the matrix, then one more sample on the inverted-span key
    queue_item(make_item(kdnh_pkg::OP_CAL, 3, 7, 0, 5, 900));
    queue_item(make_item(kdnh_pkg::OP_SAMPLE, 3, 7, 1023, 1023, 1023));
    queue_item(make_item(kdnh_pkg::OP_SAMPLE, 0, 7, 0, 0, 0));
    queue_item(make_item(kdnh_pkg::OP_SAMPLE, 3, 6, 0, 0, 0));
    wait_idle();
    run_random(230, 1'b0);
    run_levels(8'd0, 8'd0, 220, 1'b0);
    run_levels(8'd255, 8'd255, 220, 1'b0);
    run_levels(8'd200, 8'd50, 220, 1'b1);
    run_levels(8'd50, 8'd200, 220, 1'b0);
    run_levels(8'($urandom_range(255)), 8'($urandom_range(255)), 230, 1'b0);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) track_key_item(sample_in);
      if (!sample_valid || !sample_stall) begin
        if (pending.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
          sample_in <= pending.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    kdnh_pkg::result_item_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (depth_expect.size() == 0) begin
          $error("unexpected item row %0d col %0d", result_out.out_row, result_out.out_col);
          mismatches++;
        end else begin
          want = depth_expect.pop_front();
          if (result_out.out_row !== want.out_row) begin
            $error("out_row expected %0d actual %0d", want.out_row, result_out.out_row);
            mismatches++;
          end
          if (result_out.out_col !== want.out_col) begin
            $error("out_col expected %0d actual %0d", want.out_col, result_out.out_col);
            mismatches++;
          end
          if (result_out.key_depth !== want.key_depth) begin
            $error("key_depth expected %0d actual %0d", want.key_depth, result_out.key_depth);
            mismatches++;
          end
          if (result_out.key_pressed !== want.key_pressed) begin
            $error("key_pressed expected %0d actual %0d", want.key_pressed,
                   result_out.key_pressed);
            mismatches++;
          end
        end
        results_seen++;
      end
      // one long back-pressure window so the input side fills up
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 80) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !steady && ($urandom_range(99) < 28);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

[files.f]
+incdir+design
design/kdnh_pkg.sv
design/kdnh_store.sv
design/kdnh_div.sv
design/key_depth_normalize_hysteresis.sv
design/kdnh_chk.sv
verif/tb.sv
